[design/sal_pkg.sv]
// shared types and constants for the shifting array list
`timescale 1ns / 1ps
`default_nettype none
package sal_pkg;

  localparam int unsigned DefDepth = 16;
  localparam int unsigned MaxDepth = 256;
  localparam int unsigned WordW    = 32;
  // cell position bus covers the largest supported depth
  localparam int unsigned PosW     = $clog2(MaxDepth);

  typedef enum logic [3:0] {
    KIND_PUSH_BACK  = 4'd0,
    KIND_PUSH_FRONT = 4'd1,
    KIND_POP_BACK   = 4'd2,
    KIND_POP_FRONT  = 4'd3,
    KIND_INSERT     = 4'd4,
    KIND_REMOVE     = 4'd5,
    KIND_READ       = 4'd6,
    KIND_WRITE      = 4'd7,
    KIND_CLEAR      = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_RANGE    = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_APPLY
  } fsm_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_WRITE,
    CELL_DELETE,
    CELL_MATCH,
    CELL_SCAN,
    CELL_REMOVE
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [PosW-1:0]   pos;
    logic [PosW:0]     cnt;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[design/shifting_array_list_top.sv]
// top level: request decode, fill count and the row of list cells
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of signed 32-bit words in a row of DEPTH cells. A request is taken when start
// is high and busy is low; its single result shows on read_value_o and status_o for exactly
// one cycle, flagged by done_o, the cycle after the request (or after the search) ends, and
// count_o keeps the new fill count. The receiver cannot hold a result off. Every request
// except remove needs no further state, since each cell loads from itself, its neighbours or
// the request word in the same edge. Remove compares all cells when taken, ripples the
// first-hit flag down the row while scanning and closes the gap in apply; busy is high meanwhile.
module shifting_array_list_top #(
  parameter int unsigned DEPTH = sal_pkg::DefDepth,
  parameter int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [3:0]                        kind_i,
  input  wire logic signed [sal_pkg::WordW-1:0]  value_i,
  input  wire logic [3:0]                        position_i,
  output logic                                   done_o,
  output logic signed [sal_pkg::WordW-1:0]       read_value_o,
  output logic [CntW-1:0]                        count_o,
  output logic [2:0]                             status_o
);
  import sal_pkg::*;

  localparam int unsigned IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW   = IW;
  localparam int unsigned CmpW = (CntW > 4) ? CntW : 4;

  fsm_e             state_q, state_d;
  logic [SW-1:0]    step_q, step_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             done_q, done_d;
  logic [WordW-1:0] rdata_q, rdata_d;
  status_e          status_q, status_d;

  cell_ctrl_t       ctrl;
  logic [WordW-1:0] entry [DEPTH];
  logic             seen [DEPTH];

  logic             accept, full, empty, pos_ok, found;
  kind_e            kind;

  assign accept = start && (state_q == FSM_IDLE);
  assign kind   = kind_e'(kind_i);
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);
  assign pos_ok = (CmpW'(position_i) < CmpW'(count_q));
  assign found  = seen[DEPTH-1];

  // row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WordW-1:0] left_w, right_w;
    logic             seen_in_w;
    if (g == 0) begin : g_first
      assign left_w    = '0;
      assign seen_in_w = 1'b0;
    end else begin : g_mid
      assign left_w    = entry[g-1];
      assign seen_in_w = seen[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = entry[g];
    end else begin : g_inner
      assign right_w = entry[g+1];
    end
    sal_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .value_i (value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .seen_i  (seen_in_w),
      .entry_o (entry[g]),
      .seen_o  (seen[g])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = '0;
    case (state_q)
      FSM_IDLE: begin
        if (accept && (kind == KIND_REMOVE)) begin
          state_d = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        step_d = step_q + SW'(1);
        if (step_q == SW'(DEPTH - 2)) begin
          state_d = FSM_APPLY;
        end
      end
      FSM_APPLY: begin
        state_d = FSM_IDLE;
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // cell control and result
  always_comb begin
    ctrl.op  = CELL_HOLD;
    ctrl.pos = '0;
    ctrl.cnt = (PosW + 1)'(count_q);
    count_d  = count_q;
    done_d   = 1'b0;
    rdata_d  = '0;
    status_d = STAT_OK;
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          case (kind)
            KIND_PUSH_BACK: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                ctrl.op  = CELL_WRITE;
                ctrl.pos = PosW'(count_q);
                count_d  = count_q + CntW'(1);
              end
            end
            KIND_PUSH_FRONT: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                ctrl.op = CELL_INSERT;
                count_d = count_q + CntW'(1);
              end
            end
            KIND_POP_BACK: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end else begin
                count_d = count_q - CntW'(1);
              end
            end
            KIND_POP_FRONT: begin
              if (empty) begin
                status_d = STAT_EMPTY;
              end else begin
                ctrl.op = CELL_DELETE;
                count_d = count_q - CntW'(1);
              end
            end
            KIND_INSERT: begin
              if (!pos_ok) begin
                status_d = STAT_RANGE;
              end else if (full) begin
                status_d = STAT_FULL;
              end else begin
                ctrl.op  = CELL_INSERT;
                ctrl.pos = PosW'(position_i);
                count_d  = count_q + CntW'(1);
              end
            end
            KIND_REMOVE: begin
              ctrl.op = CELL_MATCH;
              done_d  = 1'b0;
            end
            KIND_READ: begin
              if (!pos_ok) begin
                status_d = STAT_RANGE;
              end else begin
                rdata_d = entry[IW'(position_i)];
              end
            end
            KIND_WRITE: begin
              if (!pos_ok) begin
                status_d = STAT_RANGE;
              end else begin
                ctrl.op  = CELL_WRITE;
                ctrl.pos = PosW'(position_i);
              end
            end
            KIND_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      FSM_SCAN: begin
        ctrl.op = CELL_SCAN;
      end
      FSM_APPLY: begin
        done_d = 1'b1;
        if (found) begin
          ctrl.op = CELL_REMOVE;
          count_d = count_q - CntW'(1);
        end else begin
          status_d = STAT_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      step_q   <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= STAT_OK;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      count_q  <= count_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
  end

  assign busy         = (state_q != FSM_IDLE);
  assign done_o       = done_q;
  assign read_value_o = rdata_q;
  assign count_o      = count_q;
  assign status_o     = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count above depth");

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind != KIND_REMOVE)) |=> done_o)
    else $error("single-cycle request gave no result");

  a_count_moves_with_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_o) |-> done_o)
    else $error("count changed without a result beat");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == FSM_IDLE))
    else $error("result beat while a search is under way");

endmodule
`default_nettype wire

[design/sal_cell.sv]
// one list entry with its match and seen flags for the remove ripple
`timescale 1ns / 1ps
`default_nettype none
module sal_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire sal_pkg::cell_ctrl_t         ctrl_i,
  input  wire logic [sal_pkg::WordW-1:0]   value_i,
  input  wire logic [sal_pkg::WordW-1:0]   left_i,
  input  wire logic [sal_pkg::WordW-1:0]   right_i,
  input  wire logic                        seen_i,
  output logic [sal_pkg::WordW-1:0]        entry_o,
  output logic                             seen_o
);
  import sal_pkg::*;

  logic [WordW-1:0] entry_q, entry_d;
  logic             match_q, match_d;
  logic             seen_q, seen_d;
  logic             at_pos, above_pos, in_list;

  assign at_pos    = (PosW'(IDX) == ctrl_i.pos);
  assign above_pos = (PosW'(IDX) > ctrl_i.pos);
  assign in_list   = ((PosW + 1)'(IDX) < ctrl_i.cnt);

  always_comb begin
    entry_d = entry_q;
    match_d = match_q;
    seen_d  = seen_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        if (at_pos) begin
          entry_d = value_i;
        end else if (above_pos) begin
          entry_d = left_i;
        end
      end
      CELL_WRITE: begin
        if (at_pos) begin
          entry_d = value_i;
        end
      end
      CELL_DELETE: begin
        if (at_pos || above_pos) begin
          entry_d = right_i;
        end
      end
      CELL_MATCH: begin
        match_d = in_list && (entry_q == value_i);
        seen_d  = 1'b0;
      end
      CELL_SCAN: begin
        seen_d = seen_i;
      end
      CELL_REMOVE: begin
        // the first hit and everything after it close the gap
        if (match_q || seen_q) begin
          entry_d = right_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      match_q <= match_d;
      seen_q  <= seen_d;
    end
  end

  assign entry_o = entry_q;
  assign seen_o  = seen_q | match_q;

endmodule
`default_nettype wire
